// ----- hw/rtl/adsr_pwm_tone_sequencer_top_macros.svh -----
// Assertion helpers for the tone sequencer checker.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef ADSR_PWM_TONE_SEQUENCER_TOP_MACROS_SVH
`define ADSR_PWM_TONE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define APTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("apts: implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define APTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("apts: next-cycle check failed");

`endif

// ----- hw/rtl/apts_pkg.sv -----
package apts_pkg;

  // Item function codes.
  localparam logic [1:0] FN_TICK = 2'd0;
  localparam logic [1:0] FN_NOTE = 2'd1;
  localparam logic [1:0] FN_REST = 2'd2;

  // Envelope phase codes.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ATTACK  = 3'd1;
  localparam logic [2:0] PH_DECAY   = 3'd2;
  localparam logic [2:0] PH_SUSTAIN = 3'd3;
  localparam logic [2:0] PH_RELEASE = 3'd4;
  localparam logic [2:0] PH_REST    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_RELEASE = 2'd2;
  localparam logic [1:0] REG_SUSTAIN = 2'd3;

  localparam logic [8:0] LEVEL_FULL  = 9'd256;
  localparam int unsigned UNIT_MS     = 200;
  localparam int unsigned OCTAVE_COUNT = 9;
  localparam int unsigned NOTE_COUNT  = 12;
  localparam int unsigned PITCH_COUNT = OCTAVE_COUNT * NOTE_COUNT;
  localparam int unsigned LOG_FRAC    = 20;

  // Reciprocals for the exponent scaling and the final rounding of a curve entry.
  localparam logic [63:0] RECIP_10000 = ((64'd1 << 56) + 64'd9999) / 64'd10000;
  localparam logic [63:0] RECIP_5     = ((64'd1 << 34) + 64'd4) / 64'd5;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] octave;
    logic [3:0] note;
    logic [7:0] duration_units;
    logic       last_item;
  } apts_in_t;

  typedef struct packed {
    logic [15:0] prescaler;
    logic [15:0] period;
    logic [15:0] compare;
    logic [2:0]  phase;
    logic        item_done;
    logic        sequence_done;
    logic        rejected;
  } apts_out_t;

  typedef struct packed {
    logic [15:0] psc;
    logic [15:0] arr;
  } apts_tone_t;

  localparam apts_tone_t TONE_LUT [PITCH_COUNT] = '{
    '{16'd330,16'd9622}, '{16'd4596,16'd653}, '{16'd3220,16'd880}, '{16'd84,16'd31510},
    '{16'd293,16'd8598}, '{16'd138,16'd17166}, '{16'd161,16'd13902}, '{16'd374,16'd5668},
    '{16'd2452,16'd817}, '{16'd2830,16'd668}, '{16'd2418,16'd738}, '{16'd2652,16'd635},
    '{16'd34,16'd45502}, '{16'd30,16'd48490}, '{16'd2101,16'd674}, '{16'd2320,16'd576},
    '{16'd146,16'd8598}, '{16'd1804,16'd660}, '{16'd80,16'd13902}, '{16'd213,16'd4966},
    '{16'd408,16'd2452}, '{16'd1684,16'd561}, '{16'd59,16'd14896}, '{16'd1136,16'd741},
    '{16'd1493,16'd532}, '{16'd1313,16'd571}, '{16'd861,16'd822}, '{16'd422,16'd1582},
    '{16'd985,16'd640}, '{16'd13,16'd42610}, '{16'd847,16'd663}, '{16'd106,16'd4966},
    '{16'd39,16'd12540}, '{16'd336,16'd1404}, '{16'd29,16'd14896}, '{16'd378,16'd1112},
    '{16'd633,16'd627}, '{16'd656,16'd571}, '{16'd430,16'd822}, '{16'd446,16'd748},
    '{16'd492,16'd640}, '{16'd6,16'd42610}, '{16'd423,16'd663}, '{16'd517,16'd512},
    '{16'd19,16'd12540}, '{16'd421,16'd560}, '{16'd14,16'd14896}, '{16'd21,16'd9586},
    '{16'd316,16'd627}, '{16'd40,16'd4582}, '{16'd201,16'd877}, '{16'd162,16'd1026},
    '{16'd92,16'd1698}, '{16'd21,16'd6778}, '{16'd211,16'd663}, '{16'd258,16'd512},
    '{16'd9,16'd12540}, '{16'd210,16'd560}, '{16'd15,16'd6982}, '{16'd10,16'd9586},
    '{16'd156,16'd633}, '{16'd142,16'd656}, '{16'd100,16'd877}, '{16'd154,16'd539},
    '{16'd153,16'd512}, '{16'd10,16'd6778}, '{16'd105,16'd663}, '{16'd117,16'd562},
    '{16'd4,16'd12540}, '{16'd100,16'd585}, '{16'd7,16'd6982}, '{16'd103,16'd506},
    '{16'd0,16'd49768}, '{16'd63,16'd733}, '{16'd0,16'd44338}, '{16'd0,16'd41850},
    '{16'd1,16'd19750}, '{16'd4,16'd7456}, '{16'd52,16'd663}, '{16'd58,16'd562},
    '{16'd7,16'd3918}, '{16'd0,16'd29592}, '{16'd3,16'd6982}, '{16'd51,16'd506},
    '{16'd3,16'd6220}, '{16'd31,16'd733}, '{16'd29,16'd738}, '{16'd30,16'd674},
    '{16'd0,16'd19750}, '{16'd25,16'd716}, '{16'd3,16'd4398}, '{16'd31,16'd518},
    '{16'd3,16'd3918}, '{16'd26,16'd547}, '{16'd1,16'd6982}, '{16'd25,16'd506},
    '{16'd1,16'd6220}, '{16'd15,16'd733}, '{16'd14,16'd738}, '{16'd0,16'd10462},
    '{16'd4,16'd1974}, '{16'd12,16'd716}, '{16'd1,16'd4398}, '{16'd15,16'd518},
    '{16'd1,16'd3918}, '{16'd8,16'd821}, '{16'd0,16'd6982}, '{16'd12,16'd506}
  };

  // Pitch table read; indexes past the table are never produced.
  function automatic apts_tone_t tone_lookup(input logic [6:0] pitch);
    apts_tone_t t;
    t = TONE_LUT[0];
    if (32'(pitch) < PITCH_COUNT) begin
      t = TONE_LUT[pitch];
    end
    return t;
  endfunction

  // Integer square root, used only while building the curve table.
  function automatic logic [63:0] isqrt64(input logic [63:0] value);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = value;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > v) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Base-two logarithm in Q.20 by repeated squaring.
  function automatic logic [31:0] log2_q20(input logic [31:0] n);
    logic [31:0] k;
    logic [63:0] m;
    logic [31:0] r;
    k = 32'd0;
    for (int j = 0; j < 30; j++) begin
      if (k < 32'd30 && (n >> (k + 32'd1)) != 32'd0) k = k + 32'd1;
    end
    m = 64'(n) << (32'd30 - k);
    r = k << LOG_FRAC;
    for (int b = LOG_FRAC - 1; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r = r | (32'd1 << b);
      end
    end
    return r;
  endfunction

  // One loudness curve entry: 0.4 * (i / d)^2.7777 in Q0.16.
  function automatic logic [15:0] curve_entry(input int unsigned i, input int unsigned d);
    logic [63:0] root [LOG_FRAC];
    logic [31:0] ld;
    logic [31:0] li;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] f;
    logic [63:0] v;
    logic [63:0] res;
    logic [127:0] wide;
    root[0] = isqrt64(64'd1 << 59);
    for (int b = 1; b < LOG_FRAC; b++) begin
      root[b] = isqrt64(root[b-1] << 30);
    end
    ld = log2_q20(32'(d));
    li = log2_q20(32'(i));
    t  = (ld > li) ? 64'(ld - li) : 64'd0;
    // Scale by 2.7777, truncated, through an exact reciprocal product.
    wide = 128'(t * 64'd27777) * 128'(RECIP_10000);
    s  = wide[119:56];
    q  = s >> LOG_FRAC;
    f  = s & ((64'd1 << LOG_FRAC) - 64'd1);
    v  = 64'd1 << 30;
    for (int b = 0; b < LOG_FRAC; b++) begin
      if (f[LOG_FRAC-1-b]) v = (v * root[b]) >> 30;
    end
    v   = (q >= 64'd31) ? 64'd0 : (v >> q);
    // Round to Q0.16 at 0.4 of full scale: shift by 2^31, then divide by five.
    res = (v * 64'd262144 + 64'd5 * (64'd1 << 30)) >> 31;
    res = (res * RECIP_5) >> 34;
    if (i == 0) res = 64'd0;
    return res[15:0];
  endfunction

endpackage

// ----- hw/rtl/apts_if.sv -----
// Input word channel.
interface apts_in_if;
  logic              valid;
  logic              ready;
  apts_pkg::apts_in_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// Result word channel.
interface apts_out_if;
  logic               valid;
  logic               ready;
  apts_pkg::apts_out_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// Configuration write channel.
interface apts_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ----- hw/rtl/adsr_pwm_tone_sequencer_top.sv -----
// Steps: idle, rest, rejected and no-op words go from acceptance through the level state to the result;
// a note steps through each phase it enters in turn, and while a fade is active the level passes
// through the serial divider, the curve ROM read and the compare multiply before the result.
// Throughput: one word at a time; the next is taken once the result is registered.
// Reset: asynchronous, active low; clears the envelope to idle and the registers
// to attack 10, decay 50, release 100 ms and sustain level 179.
module adsr_pwm_tone_sequencer_top #(
  parameter int unsigned CURVE_ENTRIES = 257
) (
  input logic        clk_i,
  input logic        rst_ni,
  apts_in_if.sink    item_i,
  apts_out_if.source result_o,
  apts_cfg_if.sink   cfg_i
);
  import apts_pkg::*;

  localparam int unsigned CW   = $clog2(CURVE_ENTRIES);
  localparam int unsigned CMAX = CURVE_ENTRIES - 1;
  localparam int unsigned IW   = 10 + CW;
  localparam int unsigned DW   = 25;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENTER = 3'd1;
  localparam logic [2:0] S_LEVEL = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_ROM   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]  state_q;
  logic [15:0] attack_q, decay_q, release_q;
  logic [8:0]  sus_lvl_q;
  logic [2:0]  phase_q, enter_ph_q;
  logic [15:0] elapsed_q, length_q, sus_len_q;
  logic [8:0]  start_lvl_q, end_lvl_q;
  logic [6:0]  pitch_q;
  logic        last_q, done_q, rej_q, seq_q;
  apts_tone_t  tone_q;
  logic [CW-1:0] idx_q;
  logic [15:0] compare_q;
  logic        out_valid_q;
  apts_out_t   out_q;

  logic        accept;
  logic [8:0]  sus_c;
  logic        fading;
  logic [8:0]  diff;
  logic        rising;
  logic        div_start, div_busy;
  logic [DW-1:0] div_quot;
  logic [15:0] curve;
  logic [15:0] ent_len;
  logic [8:0]  ent_start, ent_end;
  logic [15:0] el_inc;
  logic [23:0] dur;
  logic [17:0] adr;
  logic [15:0] dur_sat, sus_sat;
  logic [3:0]  oct_c, note_c;
  logic [9:0]  lvl;
  logic [8:0]  lvl_c;
  logic [IW-1:0] scaled;
  logic [IW-9:0] idx_full;
  logic [32:0] cmp_prod;

  assign accept      = item_i.valid && item_i.ready;
  assign item_i.ready = state_q == S_IDLE;
  assign cfg_i.ready = 1'b1;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= 16'd10;
      decay_q   <= 16'd50;
      release_q <= 16'd100;
      sus_lvl_q <= 9'd179;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ATTACK:  attack_q  <= cfg_i.wdata;
        REG_DECAY:   decay_q   <= cfg_i.wdata;
        REG_RELEASE: release_q <= cfg_i.wdata;
        REG_SUSTAIN: sus_lvl_q <= cfg_i.wdata[8:0];
        default: ;
      endcase
    end
  end

  assign sus_c = (sus_lvl_q > LEVEL_FULL) ? LEVEL_FULL : sus_lvl_q;

  // Length and levels of the phase being entered.
  always_comb begin
    ent_len   = 16'd0;
    ent_start = 9'd0;
    ent_end   = 9'd0;
    case (enter_ph_q)
      PH_ATTACK: begin
        ent_len = attack_q;
        ent_end = LEVEL_FULL;
      end
      PH_DECAY: begin
        ent_len   = decay_q;
        ent_start = LEVEL_FULL;
        ent_end   = sus_c;
      end
      PH_SUSTAIN: begin
        ent_len   = sus_len_q;
        ent_start = sus_c;
        ent_end   = sus_c;
      end
      PH_RELEASE: begin
        ent_len   = release_q;
        ent_start = sus_c;
      end
      default: ;
    endcase
  end

  // Note and rest lengths from the start word.
  assign oct_c   = (item_i.data.octave > 4'(OCTAVE_COUNT - 1)) ?
                   4'(OCTAVE_COUNT - 1) : item_i.data.octave;
  assign note_c  = (item_i.data.note > 4'(NOTE_COUNT - 1)) ?
                   4'(NOTE_COUNT - 1) : item_i.data.note;
  assign dur     = 24'(item_i.data.duration_units) * 24'(UNIT_MS);
  assign adr     = 18'(attack_q) + 18'(decay_q) + 18'(release_q);
  assign dur_sat = (dur > 24'hFFFF) ? 16'hFFFF : dur[15:0];
  assign sus_sat = (dur <= 24'(adr)) ? 16'd0 :
                   ((dur - 24'(adr)) > 24'hFFFF) ? 16'hFFFF : 16'(dur - 24'(adr));
  assign el_inc  = (elapsed_q < length_q) ? elapsed_q + 16'd1 : elapsed_q;

  // Fade level: start +- diff * elapsed / length on the serial divider.
  assign fading    = (phase_q >= PH_ATTACK) && (phase_q <= PH_RELEASE);
  assign rising    = end_lvl_q >= start_lvl_q;
  assign diff      = rising ? end_lvl_q - start_lvl_q : start_lvl_q - end_lvl_q;
  assign div_start = (state_q == S_LEVEL) && fading;

  apts_div #(.DW(DW), .VW(16)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(DW'(diff) * DW'(elapsed_q)),
    .divisor_i (length_q),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  assign lvl      = rising ? 10'(start_lvl_q) + 10'(div_quot[8:0]) :
                             10'(start_lvl_q) - 10'(div_quot[8:0]);
  assign lvl_c    = (lvl > 10'(LEVEL_FULL)) ? LEVEL_FULL : lvl[8:0];
  assign scaled   = IW'(lvl_c) * IW'(CMAX) + IW'(128);
  assign idx_full = scaled[IW-1:8];

  apts_curve_rom #(.ENTRIES(CURVE_ENTRIES), .AW(CW)) u_rom (
    .clk_i (clk_i),
    .addr_i(idx_q),
    .data_o(curve)
  );

  assign cmp_prod = 33'(tone_q.arr) * 33'(curve) + 33'd32768;

  // Sequencer and envelope state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      enter_ph_q  <= PH_IDLE;
      elapsed_q   <= '0;
      length_q    <= '0;
      sus_len_q   <= '0;
      start_lvl_q <= '0;
      end_lvl_q   <= '0;
      pitch_q     <= '0;
      last_q      <= 1'b0;
      done_q      <= 1'b0;
      rej_q       <= 1'b0;
      seq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && result_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            done_q  <= 1'b0;
            rej_q   <= 1'b0;
            seq_q   <= 1'b0;
            state_q <= S_LEVEL;
            case (item_i.data.func) inside
              FN_TICK: begin
                if (phase_q != PH_IDLE) begin
                  elapsed_q <= el_inc;
                  if (el_inc >= length_q) begin
                    enter_ph_q <= (phase_q == PH_REST) ? PH_IDLE : phase_q + 3'd1;
                    state_q    <= S_ENTER;
                  end
                end
              end
              FN_NOTE, FN_REST: begin
                if (phase_q != PH_IDLE) begin
                  rej_q <= 1'b1;
                end else begin
                  last_q <= item_i.data.last_item;
                  if (item_i.data.func == FN_NOTE) begin
                    pitch_q    <= 7'(oct_c) * 7'(NOTE_COUNT) + 7'(note_c);
                    sus_len_q  <= sus_sat;
                    enter_ph_q <= PH_ATTACK;
                    state_q    <= S_ENTER;
                  end else begin
                    elapsed_q   <= '0;
                    length_q    <= dur_sat;
                    start_lvl_q <= '0;
                    end_lvl_q   <= '0;
                    phase_q     <= (dur_sat == 16'd0) ? PH_IDLE : PH_REST;
                    done_q      <= dur_sat == 16'd0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_ENTER: begin
          // One phase per cycle; zero-length phases fall through.
          elapsed_q <= '0;
          if (enter_ph_q == PH_IDLE) begin
            phase_q  <= PH_IDLE;
            length_q <= '0;
            done_q   <= 1'b1;
            state_q  <= S_LEVEL;
          end else begin
            phase_q     <= enter_ph_q;
            length_q    <= ent_len;
            start_lvl_q <= ent_start;
            end_lvl_q   <= ent_end;
            if (ent_len != 16'd0) begin
              state_q <= S_LEVEL;
            end else begin
              enter_ph_q <= (enter_ph_q >= PH_RELEASE) ? PH_IDLE : enter_ph_q + 3'd1;
            end
          end
        end
        S_LEVEL: begin
          if (done_q) begin
            seq_q  <= last_q;
            last_q <= 1'b0;
          end
          state_q <= fading ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (!div_busy) state_q <= S_ROM;
        end
        S_ROM: state_q <= S_MUL;
        S_MUL: state_q <= S_OUT;
        S_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LEVEL) begin
      tone_q    <= tone_lookup(pitch_q);
      compare_q <= '0;
    end
    if (state_q == S_DIV) begin
      idx_q <= (idx_full > (IW-8)'(CMAX)) ? CW'(CMAX) : idx_full[CW-1:0];
    end
    if (state_q == S_MUL) begin
      compare_q <= cmp_prod[31:16];
    end
    if (state_q == S_OUT && !out_valid_q) begin
      out_q.prescaler     <= tone_q.psc;
      out_q.period        <= tone_q.arr;
      out_q.compare       <= compare_q;
      out_q.phase         <= phase_q;
      out_q.item_done     <= done_q;
      out_q.sequence_done <= seq_q;
      out_q.rejected      <= rej_q;
    end
  end
endmodule

// ----- hw/rtl/apts_div.sv -----
// Restoring divider, one quotient bit per cycle.
module apts_div #(
  parameter int unsigned DW = 25,
  parameter int unsigned VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o
);
  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   dvd_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dvs_q;
  logic [VW:0]     trial;
  logic            fits;

  // Shift the next dividend bit into the partial remainder.
  assign trial  = {rem_q, dvd_q[DW-1]};
  assign fits   = trial >= {1'b0, dvs_q};
  assign busy_o = cnt_q != '0;
  assign quot_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNTW'(DW);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CNTW'(1);
    end
  end

  // The quotient shifts into the dividend register; the remainder has its own register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_o) begin
      rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
      dvd_q <= {dvd_q[DW-2:0], fits};
    end
  end
endmodule

// ----- hw/rtl/apts_curve_rom.sv -----
// Loudness curve lookup with a registered read.
module apts_curve_rom #(
  parameter int unsigned ENTRIES = 257,
  parameter int unsigned AW = 9
) (
  input  logic          clk_i,
  input  logic [AW-1:0] addr_i,
  output logic [15:0]   data_o
);
  import apts_pkg::*;

  logic [15:0] lut [ENTRIES];
  logic [15:0] data_q;

  // Entries are constants folded at elaboration.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_lut
    assign lut[g] = curve_entry(g, ENTRIES - 1);
  end

  always_ff @(posedge clk_i) begin
    data_q <= lut[addr_i];
  end

  assign data_o = data_q;
endmodule

// ----- hw/rtl/apts_checker.sv -----
`include "adsr_pwm_tone_sequencer_top_macros.svh"

// Port-level checks on the result channel.
module apts_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input apts_pkg::apts_out_t out_data_i
);
  import apts_pkg::*;

  // A stalled result word holds.
  `APTS_ASSERT_NXT(a_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))
  // Silence while idle or resting.
  `APTS_ASSERT_IMP(a_quiet, out_valid_i && (out_data_i.phase == PH_IDLE || out_data_i.phase == PH_REST), out_data_i.compare == 16'd0)
  // Sequence end only comes with an item end.
  `APTS_ASSERT_IMP(a_seq, out_valid_i && out_data_i.sequence_done, out_data_i.item_done)
  // A rejected start finishes nothing.
  `APTS_ASSERT_IMP(a_rej, out_valid_i && out_data_i.rejected, !out_data_i.item_done)
endmodule

bind adsr_pwm_tone_sequencer_top apts_checker u_apts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_data_i (result_o.data)
);

// ----- dv/tb_adsr_pwm_tone_sequencer_top.sv -----
module tb_adsr_pwm_tone_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import apts_pkg::*;

  localparam int unsigned CURVE_N = 257;

  typedef struct {
    apts_in_t w;
    bit       drain;
  } pending_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  apts_in_if  item_if ();
  apts_out_if res_if ();
  apts_cfg_if cfg_if ();

  adsr_pwm_tone_sequencer_top #(.CURVE_ENTRIES(CURVE_N)) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Loudness curve and the envelope state as the block should hold it.
  logic [15:0] loud_curve [CURVE_N];
  logic [15:0] t_attack, t_decay, t_release;
  logic [8:0]  sus_lvl;
  logic [2:0]  env_phase;
  logic [15:0] env_elapsed, env_len, sus_len;
  logic [8:0]  lvl_from, lvl_to;
  logic [6:0]  pitch;
  bit          last_flag;

  pending_word_t word_q [$];
  apts_out_t     result_q [$];
  int            mismatches = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Base-two log in Q.20, fraction bits found by repeated squaring.
  function automatic longint unsigned log2_fix(longint unsigned n);
    longint unsigned k, m, r;
    k = 0;
    while (k < 30 && (n >> (k + 1)) != 0) k++;
    m = n << (30 - k);
    r = k << 20;
    for (int b = 19; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r = r | (64'd1 << b);
      end
    end
    return r;
  endfunction

  function automatic void build_loudness();
    longint unsigned roots [20];
    longint unsigned ld, li, t, s, q, f, v;
    roots[0] = int_sqrt(64'd1 << 59);
    for (int b = 1; b < 20; b++) roots[b] = int_sqrt(roots[b-1] << 30);
    ld = log2_fix(CURVE_N - 1);
    loud_curve[0] = 16'd0;
    for (int i = 1; i < CURVE_N; i++) begin
      li = log2_fix(i);
      t = (ld > li) ? ld - li : 0;
      s = t * 27777 / 10000;
      q = s >> 20;
      f = s & ((64'd1 << 20) - 1);
      v = 64'd1 << 30;
      for (int b = 0; b < 20; b++) begin
        if ((f >> (19 - b)) & 1) v = (v * roots[b]) >> 30;
      end
      v = (q >= 31) ? 0 : (v >> q);
      loud_curve[i] = 16'((v * 262144 + 5 * (64'd1 << 30)) / (10 * (64'd1 << 30)));
    end
  endfunction

  // Enter an envelope phase, falling through any phase of zero length.
  function automatic void env_enter(logic [2:0] p);
    logic [8:0] s;
    bit stop;
    s = (sus_lvl > LEVEL_FULL) ? LEVEL_FULL : sus_lvl;
    stop = 0;
    while (!stop) begin
      env_phase = p;
      env_elapsed = 0;
      case (p)
        PH_ATTACK: begin
          env_len = t_attack; lvl_from = 0; lvl_to = LEVEL_FULL;
        end
        PH_DECAY: begin
          env_len = t_decay; lvl_from = LEVEL_FULL; lvl_to = s;
        end
        PH_SUSTAIN: begin
          env_len = sus_len; lvl_from = s; lvl_to = s;
        end
        PH_RELEASE: begin
          env_len = t_release; lvl_from = s; lvl_to = 0;
        end
        default: begin
          env_phase = PH_IDLE; env_len = 0; stop = 1;
        end
      endcase
      if (!stop) begin
        if (env_len != 0) stop = 1;
        else p = (p >= PH_RELEASE) ? PH_IDLE : p + 3'd1;
      end
    end
  endfunction

  // Advance the envelope by one word and return the result it should produce.
  function automatic apts_out_t tone_step(apts_in_t w);
    apts_out_t o;
    int unsigned dur, adr, oct, nt, a, z, e, n, lvl, idx;
    bit done, rej;
    apts_tone_t tn;
    done = 0;
    rej = 0;
    if (w.func == FN_TICK) begin
      if (env_phase >= PH_ATTACK && env_phase <= PH_REST) begin
        if (env_elapsed < env_len) env_elapsed++;
        if (env_elapsed >= env_len) begin
          if (env_phase == PH_REST) env_enter(PH_IDLE);
          else env_enter(env_phase + 3'd1);
          if (env_phase == PH_IDLE) done = 1;
        end
      end
    end else if (w.func == FN_NOTE || w.func == FN_REST) begin
      if (env_phase != PH_IDLE) begin
        rej = 1;
      end else begin
        dur = UNIT_MS * w.duration_units;
        last_flag = w.last_item;
        if (w.func == FN_NOTE) begin
          adr = t_attack + t_decay + t_release;
          oct = (w.octave > 8) ? 8 : w.octave;
          nt = (w.note > 11) ? 11 : w.note;
          pitch = 7'(oct * NOTE_COUNT + nt);
          sus_len = (dur > adr) ? ((dur - adr > 65535) ? 16'hFFFF : 16'(dur - adr)) : 16'd0;
          env_enter(PH_ATTACK);
        end else begin
          env_phase = PH_REST;
          env_elapsed = 0;
          env_len = (dur > 65535) ? 16'hFFFF : 16'(dur);
          lvl_from = 0;
          lvl_to = 0;
          if (env_len == 0) env_phase = PH_IDLE;
        end
        if (env_phase == PH_IDLE) done = 1;
      end
    end
    tn = TONE_LUT[pitch];
    o.prescaler = tn.psc;
    o.period = tn.arr;
    o.compare = 16'd0;
    o.phase = env_phase;
    o.item_done = done;
    o.sequence_done = done & last_flag;
    o.rejected = rej;
    if (done) last_flag = 0;
    if (env_phase >= PH_ATTACK && env_phase <= PH_RELEASE) begin
      a = lvl_from; z = lvl_to; e = env_elapsed; n = env_len;
      if (n == 0) lvl = z;
      else if (z >= a) lvl = a + (z - a) * e / n;
      else lvl = a - (a - z) * e / n;
      if (lvl > 256) lvl = 256;
      idx = (lvl * (CURVE_N - 1) + 128) >> 8;
      if (idx > CURVE_N - 1) idx = CURVE_N - 1;
      o.compare = 16'((longint'(tn.arr) * loud_curve[idx] + 32768) >> 16);
    end
    return o;
  endfunction

  task automatic queue_word(logic [1:0] func, logic [3:0] oct, logic [3:0] nt,
                            logic [7:0] units, bit last, bit drain = 0);
    pending_word_t p;
    p.w = '{func: func, octave: oct, note: nt, duration_units: units, last_item: last};
    p.drain = drain;
    result_q.push_back(tone_step(p.w));
    word_q.push_back(p);
  endtask

  // Tick until the current note or rest is over.
  task automatic tick_out();
    while (env_phase != PH_IDLE) queue_word(FN_TICK, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Random words: well-formed notes and rests with ticks, plus some noise.
  task automatic random_words(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (env_phase == PH_IDLE) begin
        if (r < 70)
          queue_word(FN_NOTE, 4'($urandom), 4'($urandom),
                     ($urandom_range(0, 9) < 8) ? 8'd0 : 8'($urandom_range(1, 2)), 1'($urandom));
        else if (r < 85)
          queue_word(FN_REST, 4'($urandom), 4'($urandom),
                     8'($urandom_range(0, 1)), 1'($urandom));
        else
          queue_word(($urandom_range(0, 1) != 0) ? FN_TICK : 2'd3, 4'($urandom),
                     4'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        if (r < 90)
          queue_word(FN_TICK, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
        else if (r < 96)
          queue_word(($urandom_range(0, 1) != 0) ? FN_NOTE : FN_REST, 4'($urandom),
                     4'($urandom), 8'($urandom), 1'($urandom));
        else
          queue_word(2'd3, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Register write, issued only once the block has gone idle.
  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    wait (word_q.size() == 0 && result_q.size() == 0);
    repeat (60) @(negedge clk_i);
    case (idx)
      REG_ATTACK:  t_attack = value;
      REG_DECAY:   t_decay = value;
      REG_RELEASE: t_release = value;
      default:     sus_lvl = value[8:0];
    endcase
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= value;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] a, logic [15:0] d, logic [15:0] r, logic [15:0] s);
    write_reg(REG_ATTACK, a);
    write_reg(REG_DECAY, d);
    write_reg(REG_RELEASE, r);
    write_reg(REG_SUSTAIN, s);
  endtask

  // Driver: words change on the falling edge, with random gaps.
  bit in_fire = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit quiet = 0;

  always @(posedge clk_i) in_fire <= item_if.valid && item_if.ready;

  always @(negedge clk_i) begin
    bit send;
    pending_word_t p;
    send = 0;
    if (rst_ni && !(item_if.valid && !in_fire)) begin
      if ($urandom_range(0, 99) == 0) quiet = !quiet;
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (word_q.size() != 0 &&
                   !(word_q[0].drain && result_q.size() != word_q.size())) begin
        p = word_q.pop_front();
        send = 1;
        if (!quiet) gap_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                          : $urandom_range(10, 40);
      end
      item_if.valid <= send;
      if (send) item_if.data <= p.w;
    end
  end

  // Monitor: random stalls on ready, mostly short with a few long ones.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        if (!quiet && $urandom_range(0, 199) == 0) stall_left = $urandom_range(10, 40);
        res_if.ready <= quiet || ($urandom_range(0, 9) < 7) ||
                        ($urandom_range(0, 29) == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    apts_out_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p", res_if.data);
      end else begin
        want = result_q.pop_front();
        if (res_if.data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected %p, got %p", want, res_if.data);
        end
      end
    end
  end

  initial begin
    item_if.valid = 1'b0;
    item_if.data = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_ATTACK;
    cfg_if.wdata = '0;
    build_loudness();
    t_attack = 16'd10; t_decay = 16'd50; t_release = 16'd100; sus_lvl = 9'd179;
    env_phase = PH_IDLE; env_elapsed = 0; env_len = 0; sus_len = 0;
    lvl_from = 0; lvl_to = 0; pitch = 0; last_flag = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: idle words, a full note with busy starts, rests and clamping.
    queue_word(FN_TICK, 4'd0, 4'd0, 8'd0, 1'b0);
    queue_word(2'd3, 4'd15, 4'd15, 8'd255, 1'b1);
    queue_word(FN_NOTE, 4'd0, 4'd0, 8'd0, 1'b1);
    queue_word(FN_TICK, 4'd0, 4'd0, 8'd0, 1'b0);
    queue_word(FN_NOTE, 4'd15, 4'd15, 8'd255, 1'b1);
    queue_word(FN_REST, 4'd0, 4'd0, 8'd255, 1'b0);
    queue_word(2'd3, 4'd0, 4'd0, 8'd0, 1'b0);
    tick_out();
    queue_word(FN_REST, 4'd0, 4'd0, 8'd1, 1'b1);
    tick_out();
    queue_word(FN_REST, 4'd0, 4'd0, 8'd0, 1'b1);
    queue_word(FN_NOTE, 4'd8, 4'd11, 8'd2, 1'b0);
    tick_out();
    queue_word(FN_NOTE, 4'd9, 4'd12, 8'd1, 1'b1, 1'b1);
    tick_out();

    // Extreme settings: zero-length phases and out-of-range sustain.
    write_all(16'd0, 16'd0, 16'd0, 16'hFFFF);
    queue_word(FN_NOTE, 4'd15, 4'd0, 8'd0, 1'b1);
    queue_word(FN_NOTE, 4'd3, 4'd5, 8'd1, 1'b1);
    tick_out();
    write_reg(REG_SUSTAIN, 16'd0);
    queue_word(FN_NOTE, 4'd2, 4'd7, 8'd1, 1'b0);
    tick_out();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd256);
    queue_word(FN_REST, 4'd1, 4'd1, 8'd0, 1'b1);
    queue_word(FN_TICK, 4'd0, 4'd0, 8'd0, 1'b0);
    write_all(16'd3, 16'd0, 16'd5, 16'd256);
    queue_word(FN_NOTE, 4'd6, 4'd2, 8'd0, 1'b1);
    tick_out();

    // Random phases, each under a new setting.
    for (int ph = 0; ph < 4; ph++) begin
      write_all(($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 20)),
                ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 20)),
                ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 20)),
                16'($urandom));
      random_words(25);
      queue_word(FN_TICK, 4'd0, 4'd0, 8'd0, 1'b0, 1'b1);
      random_words(25);
      tick_out();
    end

    wait (word_q.size() == 0 && result_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS adsr_pwm_tone_sequencer_top");
    end else begin
      $display("FAIL adsr_pwm_tone_sequencer_top");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL adsr_pwm_tone_sequencer_top");
    $finish;
  end

endmodule
